// ===== rtl/core/cgla_pkg.sv =====
package cgla_pkg;

	localparam int PARENT_FIELDS = 4;
	localparam int MAX_RESULTS   = 16;
	localparam int FIELD_W       = 16;
	localparam int PC_W          = 3;
	localparam int PI_W          = $clog2(PARENT_FIELDS);
	localparam int COL_W         = 4;
	localparam int MARK_W        = 6;

	localparam logic [MARK_W-1:0] MK_COMMIT = 6'h01;
	localparam logic [MARK_W-1:0] MK_CHILD  = 6'h02;
	localparam logic [MARK_W-1:0] MK_FORK   = 6'h04;
	localparam logic [MARK_W-1:0] MK_PASS   = 6'h08;
	localparam logic [MARK_W-1:0] MK_PARENT = 6'h10;
	localparam logic [MARK_W-1:0] MK_MERGE  = 6'h20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CSCAN,
		ST_CFIN,
		ST_PSCAN,
		ST_PFIN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

	typedef struct packed {
		logic match;
		logic first_hit;
		logic hit_found;
		logic empty_found;
	} scan_stat_t;

endpackage

// ===== rtl/core/cgla_in_if.sv =====
interface cgla_in_if import cgla_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               restart;
	logic [PC_W-1:0]    parent_count;
	logic [FIELD_W-1:0] parent_0;
	logic [FIELD_W-1:0] parent_1;
	logic [FIELD_W-1:0] parent_2;
	logic [FIELD_W-1:0] parent_3;

	modport source (
		output valid, restart, parent_count, parent_0, parent_1, parent_2, parent_3,
		input  ready
	);
	modport sink (
		input  valid, restart, parent_count, parent_0, parent_1, parent_2, parent_3,
		output ready
	);
endinterface

// ===== rtl/core/cgla_out_if.sv =====
interface cgla_out_if import cgla_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  column;
	logic [MARK_W-1:0] marks;
	logic              overflow;
	logic              last;

	modport source (
		output valid, column, marks, overflow, last,
		input  ready
	);
	modport sink (
		input  valid, column, marks, overflow, last,
		output ready
	);
endinterface

// ===== rtl/core/cgla_scan_unit.sv =====
module cgla_scan_unit import cgla_pkg::*; #(
	parameter int  LANES    = 16,
	parameter int  ROW_BITS = 16,
	localparam int LW       = $clog2(LANES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scan_ctl_t           ctl,
	input  logic [ROW_BITS-1:0] key,
	input  logic [ROW_BITS-1:0] expect_val,
	input  logic                busy,
	input  logic [LW-1:0]       idx,
	output scan_stat_t          stat,
	output logic [LW-1:0]       hit_idx,
	output logic [LW-1:0]       empty_idx
);

	logic hit_found_q;
	logic empty_found_q;
	logic [LW-1:0] hit_idx_q;
	logic [LW-1:0] empty_idx_q;
	logic match;

	// one lane compare per cycle
	assign match = busy && (expect_val == key);

	always_comb begin
		stat.match       = match;
		stat.first_hit   = match && !hit_found_q;
		stat.hit_found   = hit_found_q;
		stat.empty_found = empty_found_q;
	end

	assign hit_idx   = hit_idx_q;
	assign empty_idx = empty_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
		end else if (ctl.step) begin
			if (match && !hit_found_q) begin
				hit_found_q <= 1'b1;
			end
			if (!busy && !empty_found_q) begin
				empty_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && match && !hit_found_q) begin
			hit_idx_q <= idx;
		end
		if (ctl.step && !busy && !empty_found_q) begin
			empty_idx_q <= idx;
		end
	end

endmodule

// ===== rtl/core/commit_graph_lane_assigner.sv =====
// commit graph lane assigner
// item_in carries one history row: restart, parent_count and up to four parent
// row indices. result_out returns one item per lane column, from column 0 up to
// the highest marked column (at least one, at most sixteen), with the lane
// marks, the row's overflow flag and last on the final column of the row.
// a row is handled by one lane compare unit that walks the lane table one lane
// a cycle: one walk for the commit and one walk per parent, each followed by an
// update state, then one result item per cycle while result_out is ready.
// item_in.ready is high only between rows.
// a stalled result_out holds the pending item and pauses the column sweep; the
// next row may be accepted while the last result item still waits.
// reset empties every lane and zeroes the row counter; restart on an item does
// the same before that row is processed.
module commit_graph_lane_assigner import cgla_pkg::*; #(
	parameter int  LANES       = 16,
	parameter int  ROW_BITS    = 16,
	parameter int  MAX_PARENTS = 4,
	localparam int LW          = $clog2(LANES)
) (
	input  logic       clk,
	input  logic       arst_n,
	cgla_in_if.sink    item_in,
	cgla_out_if.source result_out
);

	state_t state_q, state_d;

	logic [LANES-1:0]    busy_q;
	logic [ROW_BITS-1:0] expect_q [LANES];
	logic [MARK_W-1:0]   marks_q  [LANES];
	logic [ROW_BITS-1:0] parents_q [PARENT_FIELDS];
	logic [ROW_BITS-1:0] row_q;
	logic [LW-1:0]       idx_q;
	logic [PI_W-1:0]     pidx_q;
	logic [PC_W-1:0]     pc_q;
	logic                ovf_q;
	logic [LW-1:0]       ccol_q;
	logic                ccol_ok_q;
	logic [LW-1:0]       high_q;
	logic                high_ok_q;

	logic                out_valid_q;
	logic [COL_W-1:0]    out_col_q;
	logic [MARK_W-1:0]   out_marks_q;
	logic                out_ovf_q;
	logic                out_last_q;

	logic                accept;
	logic                idx_end;
	logic                load_out;
	logic                last_parent;
	logic [PC_W-1:0]     pc_sat;
	logic [ROW_BITS-1:0] key;
	logic [LW-1:0]       lim;
	logic [LW-1:0]       pick;
	logic                pick_ok;
	logic                mk_we;
	logic [LW-1:0]       mk_addr;
	logic [MARK_W-1:0]   mk_bits;

	scan_ctl_t  scan_ctl;
	scan_stat_t scan_stat;
	logic [LW-1:0] hit_idx;
	logic [LW-1:0] empty_idx;

	cgla_scan_unit #(
		.LANES    (LANES),
		.ROW_BITS (ROW_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.key        (key),
		.expect_val (expect_q[idx_q]),
		.busy       (busy_q[idx_q]),
		.idx        (idx_q),
		.stat       (scan_stat),
		.hit_idx    (hit_idx),
		.empty_idx  (empty_idx)
	);

	assign accept      = item_in.valid && item_in.ready;
	assign idx_end     = (idx_q == LW'(LANES - 1));
	assign last_parent = ((PC_W'(pidx_q) + PC_W'(1)) == pc_q);
	assign key         = (state_q == ST_CSCAN) ? row_q : parents_q[pidx_q];

	always_comb begin
		pc_sat = item_in.parent_count;
		if (int'(pc_sat) > MAX_PARENTS) begin
			pc_sat = PC_W'(MAX_PARENTS);
		end
		if (int'(pc_sat) > PARENT_FIELDS) begin
			pc_sat = PC_W'(PARENT_FIELDS);
		end
	end

	always_comb begin
		if (scan_stat.hit_found) begin
			pick    = hit_idx;
			pick_ok = 1'b1;
		end else begin
			pick    = empty_idx;
			pick_ok = scan_stat.empty_found;
		end
	end

	always_comb begin
		if (!high_ok_q) begin
			lim = '0;
		end else if (int'(high_q) > MAX_RESULTS - 1) begin
			lim = LW'(MAX_RESULTS - 1);
		end else begin
			lim = high_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CSCAN;
				end
			end
			ST_CSCAN: begin
				if (idx_end) begin
					state_d = ST_CFIN;
				end
			end
			ST_CFIN: begin
				state_d = (pc_q == '0) ? ST_EMIT : ST_PSCAN;
			end
			ST_PSCAN: begin
				if (idx_end) begin
					state_d = ST_PFIN;
				end
			end
			ST_PFIN: begin
				state_d = last_parent ? ST_EMIT : ST_PSCAN;
			end
			ST_EMIT: begin
				if (load_out && idx_q == lim) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_in.ready  = 1'b0;
		scan_ctl.clear = 1'b0;
		scan_ctl.step  = 1'b0;
		load_out       = 1'b0;
		mk_we          = 1'b0;
		mk_addr        = idx_q;
		mk_bits        = '0;
		case (state_q)
			ST_IDLE: begin
				item_in.ready  = 1'b1;
				scan_ctl.clear = 1'b1;
			end
			ST_CSCAN: begin
				scan_ctl.step = 1'b1;
				if (scan_stat.match) begin
					mk_we   = 1'b1;
					mk_bits = scan_stat.first_hit ? (MK_COMMIT | MK_CHILD) : MK_FORK;
				end else if (busy_q[idx_q]) begin
					mk_we   = 1'b1;
					mk_bits = MK_PASS;
				end
			end
			ST_CFIN: begin
				scan_ctl.clear = 1'b1;
				if (!scan_stat.hit_found && scan_stat.empty_found) begin
					mk_we   = 1'b1;
					mk_addr = empty_idx;
					mk_bits = MK_COMMIT;
				end
			end
			ST_PSCAN: begin
				scan_ctl.step = 1'b1;
			end
			ST_PFIN: begin
				scan_ctl.clear = 1'b1;
				mk_we          = pick_ok;
				mk_addr        = pick;
				mk_bits        = (ccol_ok_q && pick == ccol_q) ? MK_PARENT : MK_MERGE;
			end
			ST_EMIT: begin
				load_out = !out_valid_q || result_out.ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			busy_q    <= '0;
			row_q     <= '0;
			idx_q     <= '0;
			pidx_q    <= '0;
			pc_q      <= '0;
			ovf_q     <= 1'b0;
			ccol_ok_q <= 1'b0;
			high_ok_q <= 1'b0;
			high_q    <= '0;
			for (int i = 0; i < LANES; i++) begin
				marks_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (mk_we) begin
				marks_q[mk_addr] <= marks_q[mk_addr] | mk_bits;
				if (!high_ok_q || mk_addr > high_q) begin
					high_q    <= mk_addr;
					high_ok_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item_in.restart) begin
							busy_q <= '0;
							row_q  <= '0;
						end
						pc_q      <= pc_sat;
						pidx_q    <= '0;
						idx_q     <= '0;
						ovf_q     <= 1'b0;
						high_ok_q <= 1'b0;
						high_q    <= '0;
						for (int i = 0; i < LANES; i++) begin
							marks_q[i] <= '0;
						end
					end
				end
				ST_CSCAN: begin
					if (scan_stat.match) begin
						busy_q[idx_q] <= 1'b0;
					end
					idx_q <= idx_end ? '0 : idx_q + LW'(1);
				end
				ST_CFIN: begin
					if (scan_stat.hit_found) begin
						ccol_q    <= hit_idx;
						ccol_ok_q <= 1'b1;
					end else if (scan_stat.empty_found) begin
						ccol_q    <= empty_idx;
						ccol_ok_q <= 1'b1;
					end else begin
						ccol_ok_q <= 1'b0;
						ovf_q     <= 1'b1;
					end
				end
				ST_PSCAN: begin
					idx_q <= idx_end ? '0 : idx_q + LW'(1);
				end
				ST_PFIN: begin
					if (pick_ok) begin
						busy_q[pick] <= 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
					pidx_q <= pidx_q + PI_W'(1);
				end
				ST_EMIT: begin
					if (load_out) begin
						if (idx_q == lim) begin
							idx_q <= '0;
							row_q <= row_q + ROW_BITS'(1);
						end else begin
							idx_q <= idx_q + LW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			parents_q[0] <= ROW_BITS'(item_in.parent_0);
			parents_q[1] <= ROW_BITS'(item_in.parent_1);
			parents_q[2] <= ROW_BITS'(item_in.parent_2);
			parents_q[3] <= ROW_BITS'(item_in.parent_3);
		end
		if (state_q == ST_PFIN && pick_ok) begin
			expect_q[pick] <= parents_q[pidx_q];
		end
		if (load_out) begin
			out_col_q   <= COL_W'(idx_q);
			out_marks_q <= marks_q[idx_q];
			out_ovf_q   <= ovf_q;
			out_last_q  <= (idx_q == lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_out.valid    = out_valid_q;
	assign result_out.column   = out_col_q;
	assign result_out.marks    = out_marks_q;
	assign result_out.overflow = out_ovf_q;
	assign result_out.last     = out_last_q;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	import cgla_pkg::*;

	localparam int LANE_N   = 16;
	localparam int ROW_W    = 16;
	localparam int PAR_MAX  = 4;
	localparam int N_RAND   = 370;
	localparam int IDLE_PCT = 31;
	localparam int NO_COL   = -1;
	localparam int MAX_SHOW = 10;

	typedef logic [PARENT_FIELDS-1:0][FIELD_W-1:0] par_vec_t;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [MARK_W-1:0] marks;
		logic              overflow;
		logic              last;
	} col_word_t;

	class lane_scoreboard;
		bit               busy [LANE_N];
		logic [ROW_W-1:0] lane_row [LANE_N];
		logic [ROW_W-1:0] row_cnt;
		col_word_t        pending [$];
		int               errors;

		function new();
			clear_lanes();
			errors = 0;
		endfunction

		function void clear_lanes();
			foreach (busy[i]) begin
				busy[i]     = 1'b0;
				lane_row[i] = '0;
			end
			row_cnt = '0;
		endfunction

		// lane already waiting for idx, else first free lane
		function int pick_lane(logic [ROW_W-1:0] idx);
			for (int i = 0; i < LANE_N; i++)
				if (busy[i] && lane_row[i] == idx)
					return i;
			for (int i = 0; i < LANE_N; i++)
				if (!busy[i])
					return i;
			return NO_COL;
		endfunction

		function void note_row(bit rs, logic [PC_W-1:0] pc_in, par_vec_t par);
			logic [MARK_W-1:0] mk [LANE_N];
			logic [ROW_W-1:0]  row;
			logic [ROW_W-1:0]  pidx;
			int                ccol;
			int                pcol;
			int                npar;
			int                top;
			int                n;
			bit                ovf;
			col_word_t         w;
			if (rs)
				clear_lanes();
			foreach (mk[i])
				mk[i] = '0;
			ovf  = 1'b0;
			row  = row_cnt;
			ccol = pick_lane(row);
			if (ccol == NO_COL)
				ovf = 1'b1;
			else
				mk[ccol] |= MK_COMMIT;
			for (int i = 0; i < LANE_N; i++) begin
				if (busy[i]) begin
					if (lane_row[i] == row) begin
						mk[i]       |= (i == ccol) ? MK_CHILD : MK_FORK;
						busy[i]      = 1'b0;
						lane_row[i]  = '0;
					end else begin
						mk[i] |= MK_PASS;
					end
				end
			end
			npar = (int'(pc_in) > PAR_MAX) ? PAR_MAX : int'(pc_in);
			if (npar > PARENT_FIELDS)
				npar = PARENT_FIELDS;
			for (int k = 0; k < npar; k++) begin
				pidx = par[k][ROW_W-1:0];
				pcol = pick_lane(pidx);
				if (pcol == NO_COL) begin
					ovf = 1'b1;
				end else begin
					busy[pcol]     = 1'b1;
					lane_row[pcol] = pidx;
					mk[pcol]      |= (pcol == ccol) ? MK_PARENT : MK_MERGE;
				end
			end
			row_cnt = row + 1'b1;
			top = NO_COL;
			for (int i = 0; i < LANE_N; i++)
				if (mk[i] != '0)
					top = i;
			n = top + 1;
			if (n < 1)
				n = 1;
			if (n > MAX_RESULTS)
				n = MAX_RESULTS;
			for (int i = 0; i < n; i++) begin
				w.column   = COL_W'(i);
				w.marks    = (i < LANE_N) ? mk[i] : '0;
				w.overflow = ovf;
				w.last     = (i == n - 1);
				pending    = {pending, w};
			end
		endfunction

		function void check_word(col_word_t got);
			col_word_t exp_w;
			if (pending.size() == 0) begin
				if (errors < MAX_SHOW)
					$display("unexpected item: col %0d marks %02h ovf %0b last %0b",
						got.column, got.marks, got.overflow, got.last);
				errors++;
				return;
			end
			exp_w = pending.pop_front();
			if (got.column !== exp_w.column || got.marks !== exp_w.marks ||
					got.overflow !== exp_w.overflow || got.last !== exp_w.last) begin
				if (errors < MAX_SHOW)
					$display({"mismatch: exp col %0d marks %02h ovf %0b last %0b, ",
						"got col %0d marks %02h ovf %0b last %0b"},
						exp_w.column, exp_w.marks, exp_w.overflow, exp_w.last,
						got.column, got.marks, got.overflow, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   src_idle_en;
	bit   snk_stall_en;
	bit   snk_rdy = 1'b0;

	lane_scoreboard sb;

	cgla_in_if  in_if ();
	cgla_out_if out_if ();

	assign out_if.ready = snk_rdy;

	commit_graph_lane_assigner #(
		.LANES       (LANE_N),
		.ROW_BITS    (ROW_W),
		.MAX_PARENTS (PAR_MAX)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (in_if),
		.result_out (out_if)
	);

	always #5 clk = ~clk;

	function automatic bit gap_now(bit en);
		return en && ($urandom_range(0, 99) < IDLE_PCT);
	endfunction

	always @(negedge clk) begin
		snk_rdy <= !gap_now(snk_stall_en);
	end

	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready)
			sb.check_word({out_if.column, out_if.marks, out_if.overflow, out_if.last});
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_row(input bit rs, input logic [PC_W-1:0] pc, input par_vec_t par);
		while (gap_now(src_idle_en)) begin
			in_if.valid        = 1'b0;
			in_if.restart      = 1'($urandom);
			in_if.parent_count = PC_W'($urandom);
			in_if.parent_0     = FIELD_W'($urandom);
			@(negedge clk);
		end
		in_if.valid        = 1'b1;
		in_if.restart      = rs;
		in_if.parent_count = pc;
		in_if.parent_0     = par[0];
		in_if.parent_1     = par[1];
		in_if.parent_2     = par[2];
		in_if.parent_3     = par[3];
		do
			@(posedge clk);
		while (!in_if.ready);
		sb.note_row(rs, pc, par);
		@(negedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		bit               rs;
		logic [PC_W-1:0]  pc;
		par_vec_t         par;
		logic [ROW_W-1:0] base;
		logic [FIELD_W-1:0] prev;
		logic [FIELD_W-1:0] far;
		int               r;
		sb                 = new();
		arst_n             = 1'b0;
		src_idle_en        = 1'b1;
		snk_stall_en       = 1'b1;
		in_if.valid        = 1'b0;
		in_if.restart      = 1'b0;
		in_if.parent_count = '0;
		in_if.parent_0     = '0;
		in_if.parent_1     = '0;
		in_if.parent_2     = '0;
		in_if.parent_3     = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// short chains, merges, saturated parent counts
		send_row(1'b1, 3'd0, '0);
		send_row(1'b0, 3'd1, {16'd0, 16'd0, 16'd0, 16'd2});
		send_row(1'b0, 3'd2, {16'hFFFF, 16'd0, 16'd5, 16'd3});
		send_row(1'b0, 3'd3, {16'd0, 16'hFFFF, 16'd5, 16'd4});
		send_row(1'b0, 3'd4, {16'd0, 16'd7, 16'd6, 16'd5});
		send_row(1'b0, 3'd5, {16'd10, 16'd9, 16'd8, 16'd6});
		send_row(1'b0, 3'd6, {16'd12, 16'd11, 16'd8, 16'd7});
		send_row(1'b0, 3'd7, {16'd15, 16'd14, 16'd13, 16'd8});
		// fill every lane with rows far ahead so commits and parents find no lane
		for (int k = 0; k < 5; k++) begin
			far = 16'hF000 + FIELD_W'(4 * k);
			send_row(1'b0, 3'd4, {far + 16'd3, far + 16'd2, far + 16'd1, far});
		end
		send_row(1'b0, 3'd2, {16'd0, 16'd0, 16'hF100, 16'hF000});
		send_row(1'b1, 3'd0, '0);
		send_row(1'b1, 3'd4, {16'd0, 16'd0, 16'hFFFF, 16'hFFFF});

		for (int k = 0; k < N_RAND; k++) begin
			src_idle_en  = !(k >= 150 && k < 230);
			snk_stall_en = src_idle_en;
			rs   = ($urandom_range(0, 99) < 3);
			base = rs ? '0 : sb.row_cnt;
			r    = $urandom_range(0, 99);
			if (r < 10)
				pc = 3'd0;
			else if (r < 55)
				pc = 3'd1;
			else if (r < 80)
				pc = 3'd2;
			else if (r < 88)
				pc = 3'd3;
			else if (r < 94)
				pc = 3'd4;
			else
				pc = PC_W'($urandom_range(5, 7));
			prev = base + 16'd1;
			for (int j = 0; j < PARENT_FIELDS; j++) begin
				r = $urandom_range(0, 99);
				if (r < 72)
					par[j] = base + FIELD_W'($urandom_range(1, 8));
				else if (r < 82)
					par[j] = prev;
				else if (r < 92)
					par[j] = FIELD_W'($urandom);
				else
					par[j] = base - FIELD_W'($urandom_range(0, 3));
				prev = par[j];
			end
			send_row(rs, pc, par);
		end

		in_if.valid = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/cgla_pkg.sv
rtl/core/cgla_in_if.sv
rtl/core/cgla_out_if.sv
rtl/core/cgla_scan_unit.sv
rtl/core/commit_graph_lane_assigner.sv
sim/tb_top.sv
